FILE: hdl/dipf_pkg.sv
// ----------------------------------------------------------------------------
// dipf_pkg
// Shared types and constants for the display inactivity power controller.
// ----------------------------------------------------------------------------
package dipf_pkg;

    localparam int unsigned MS_W     = 32;
    localparam int unsigned TMO_W    = 17;
    localparam int unsigned TMO_MS_W = 27;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned SEC_W    = 23;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [PCT_W-1:0] BRIGHT_MIN = 7'd10;
    localparam logic [PCT_W-1:0] BRIGHT_MAX = 7'd100;

    // x / 1000 == (x * SEC_RECIP) >> SEC_SHIFT for every 32-bit x
    localparam int unsigned      RECIP_W   = 29;
    localparam logic [RECIP_W-1:0] SEC_RECIP = 29'd274877907;
    localparam int unsigned      SEC_SHIFT = 38;
    localparam int unsigned      PROD_W    = MS_W + RECIP_W;

    localparam logic [2:0] ACT_EVAL     = 3'd0;
    localparam logic [2:0] ACT_ACTIVITY = 3'd1;
    localparam logic [2:0] ACT_WAKE     = 3'd2;
    localparam logic [2:0] ACT_SLEEP    = 3'd3;
    localparam logic [2:0] ACT_UNSUP    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_TMO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TMO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_BRIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_BRIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_BRIGHT = 3'd4;

    localparam logic [1:0] PS_ACTIVE = 2'd0;
    localparam logic [1:0] PS_DIMMED = 2'd1;
    localparam logic [1:0] PS_SLEEP  = 2'd2;

    typedef enum logic [2:0] {
        ST_ACTIVE = 3'b001,
        ST_DIMMED = 3'b010,
        ST_SLEEP  = 3'b100
    } disp_state_t;

    typedef struct packed {
        logic [2:0]      action;
        logic [MS_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       power_state;
        logic [PCT_W-1:0] brightness;
        logic             brightness_write;
        logic             render_paused;
        logic             touch_suppressed;
        logic [SEC_W-1:0] inactive_seconds;
    } out_item_t;

    typedef struct packed {
        logic [TMO_MS_W-1:0] dim_ms;
        logic [TMO_MS_W-1:0] sleep_lim_ms;
        logic [PCT_W-1:0]    active_bright;
        logic [PCT_W-1:0]    dim_bright;
        logic [PCT_W-1:0]    sleep_bright;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       power_state;
        logic [PCT_W-1:0] brightness;
        logic             brightness_write;
        logic             render_paused;
        logic             touch_suppressed;
        logic [MS_W-1:0]  elapsed_ms;
    } mid_t;

endpackage

FILE: hdl/display_inactivity_power_fsm_unit.sv
// ----------------------------------------------------------------------------
// display_inactivity_power_fsm_unit
// Display power controller: dims and sleeps the backlight after inactivity.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_ready    | in_data  (action, now_ms)
//  output   | out_valid / out_ready  | out_data (state, brightness, flags, s)
//  config   | cfg_write              | cfg_index, cfg_data
//
//  One transaction per cycle while the output is not stalled; each result
//  passes the input register, the state stage register, then the seconds
//  multiplier into the result register.
//  Reset loads the default timeouts and brightness, display active.
//  A stalled output holds the result register; each stage keeps accepting
//  while the stage after it has room.
// ----------------------------------------------------------------------------
module display_inactivity_power_fsm_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dipf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dipf_pkg::TMO_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dipf_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dipf_pkg::out_item_t             out_data
);

    dipf_pkg::cfg_t  cfg;
    logic            mid_valid;
    logic            mid_ready;
    dipf_pkg::mid_t  mid_data;

    dipf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dipf_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data)
    );

    dipf_sec u_sec (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: hdl/dipf_cfg.sv
// ----------------------------------------------------------------------------
// dipf_cfg
// Configuration registers; timeouts are kept pre-scaled to milliseconds.
// ----------------------------------------------------------------------------
module dipf_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dipf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dipf_pkg::TMO_W-1:0]      cfg_data,
    output dipf_pkg::cfg_t                  cfg
);

    dipf_pkg::cfg_t                     cfg_reg;
    dipf_pkg::cfg_t                     cfg_next;
    logic [dipf_pkg::TMO_MS_W-1:0]      data_ms;
    logic [dipf_pkg::PCT_W-1:0]         pct;
    logic [dipf_pkg::PCT_W-1:0]         pct_sat;
    logic [dipf_pkg::PCT_W-1:0]         pct_clamp;

    always_comb
    begin
        // value * 1000 = value * 1024 - value * 16 - value * 8
        data_ms = ({{(dipf_pkg::TMO_MS_W-dipf_pkg::TMO_W){1'b0}}, cfg_data} << 10)
                - ({{(dipf_pkg::TMO_MS_W-dipf_pkg::TMO_W){1'b0}}, cfg_data} << 4)
                - ({{(dipf_pkg::TMO_MS_W-dipf_pkg::TMO_W){1'b0}}, cfg_data} << 3);
        pct       = cfg_data[dipf_pkg::PCT_W-1:0];
        pct_sat   = (pct > dipf_pkg::BRIGHT_MAX) ? dipf_pkg::BRIGHT_MAX : pct;
        pct_clamp = (pct_sat < dipf_pkg::BRIGHT_MIN) ? dipf_pkg::BRIGHT_MIN : pct_sat;

        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                dipf_pkg::REG_DIM_TMO:      cfg_next.dim_ms        = data_ms;
                dipf_pkg::REG_SLEEP_TMO:    cfg_next.sleep_lim_ms  = data_ms;
                dipf_pkg::REG_ACT_BRIGHT:   cfg_next.active_bright = pct_clamp;
                dipf_pkg::REG_DIM_BRIGHT:   cfg_next.dim_bright    = pct_sat;
                dipf_pkg::REG_SLEEP_BRIGHT: cfg_next.sleep_bright  = pct_sat;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_ms        <= 27'd60000;
            cfg_reg.sleep_lim_ms  <= 27'd120000;
            cfg_reg.active_bright <= 7'd100;
            cfg_reg.dim_bright    <= 7'd20;
            cfg_reg.sleep_bright  <= 7'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/dipf_eval.sv
// ----------------------------------------------------------------------------
// dipf_eval
// Input register, power state machine and elapsed-time stage register.
// ----------------------------------------------------------------------------
module dipf_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  dipf_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  dipf_pkg::in_item_t in_data,
    output logic               mid_valid,
    input  logic               mid_ready,
    output dipf_pkg::mid_t     mid_data
);

    logic                           in_valid_reg;
    dipf_pkg::in_item_t             in_item_reg;
    logic                           mid_valid_reg;
    dipf_pkg::mid_t                 mid_reg;
    dipf_pkg::mid_t                 mid_next;

    dipf_pkg::disp_state_t          state_reg;
    dipf_pkg::disp_state_t          state_next;
    logic [dipf_pkg::MS_W-1:0]      last_reg;
    logic [dipf_pkg::MS_W-1:0]      last_next;
    logic                           suppress_reg;
    logic                           suppress_next;
    logic                           paused_reg;
    logic                           paused_next;

    logic                           mid_en;
    logic                           step_en;
    logic [dipf_pkg::MS_W:0]        diff;
    logic [dipf_pkg::MS_W-1:0]      elapsed;
    logic                           sleep_hit;
    logic                           dim_hit;
    logic [dipf_pkg::PCT_W-1:0]     bright;
    logic                           bright_wr;
    logic                           touched;

    assign mid_en   = !mid_valid_reg || mid_ready;
    assign in_ready = !in_valid_reg || mid_en;
    assign step_en  = in_valid_reg && mid_en;

    always_comb
    begin
        diff      = {1'b0, in_item_reg.now_ms} - {1'b0, last_reg};
        elapsed   = diff[dipf_pkg::MS_W] ? '0 : diff[dipf_pkg::MS_W-1:0];
        sleep_hit = elapsed >= {{(dipf_pkg::MS_W-dipf_pkg::TMO_MS_W){1'b0}}, cfg.sleep_lim_ms};
        dim_hit   = elapsed >= {{(dipf_pkg::MS_W-dipf_pkg::TMO_MS_W){1'b0}}, cfg.dim_ms};

        state_next    = state_reg;
        last_next     = last_reg;
        suppress_next = suppress_reg;
        paused_next   = paused_reg;
        bright        = '0;
        bright_wr     = 1'b0;
        touched       = 1'b0;

        case (in_item_reg.action)
            dipf_pkg::ACT_EVAL:
            begin
                if (state_reg != dipf_pkg::ST_SLEEP && sleep_hit)
                begin
                    state_next  = dipf_pkg::ST_SLEEP;
                    paused_next = 1'b1;
                    bright      = cfg.sleep_bright;
                    bright_wr   = 1'b1;
                end
                else if (state_reg == dipf_pkg::ST_ACTIVE && dim_hit)
                begin
                    state_next = dipf_pkg::ST_DIMMED;
                    bright     = cfg.dim_bright;
                    bright_wr  = 1'b1;
                end
            end
            dipf_pkg::ACT_ACTIVITY, dipf_pkg::ACT_WAKE:
            begin
                touched   = 1'b1;
                last_next = in_item_reg.now_ms;
                if (state_reg != dipf_pkg::ST_ACTIVE
                    || in_item_reg.action == dipf_pkg::ACT_WAKE)
                begin
                    if (state_reg != dipf_pkg::ST_ACTIVE)
                    begin
                        suppress_next = 1'b1;
                    end
                    state_next  = dipf_pkg::ST_ACTIVE;
                    paused_next = 1'b0;
                    bright      = cfg.active_bright;
                    bright_wr   = 1'b1;
                end
            end
            dipf_pkg::ACT_SLEEP:
            begin
                state_next  = dipf_pkg::ST_SLEEP;
                paused_next = 1'b1;
                bright      = cfg.sleep_bright;
                bright_wr   = 1'b1;
            end
            dipf_pkg::ACT_UNSUP:
            begin
                suppress_next = 1'b0;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        case (state_next)
            dipf_pkg::ST_DIMMED: mid_next.power_state = dipf_pkg::PS_DIMMED;
            dipf_pkg::ST_SLEEP:  mid_next.power_state = dipf_pkg::PS_SLEEP;
            default:             mid_next.power_state = dipf_pkg::PS_ACTIVE;
        endcase
        mid_next.brightness       = bright;
        mid_next.brightness_write = bright_wr;
        mid_next.render_paused    = paused_next;
        mid_next.touch_suppressed = suppress_next;
        mid_next.elapsed_ms       = touched ? '0 : elapsed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            state_reg     <= dipf_pkg::ST_ACTIVE;
            last_reg      <= '0;
            suppress_reg  <= 1'b0;
            paused_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (mid_en)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (step_en)
            begin
                state_reg    <= state_next;
                last_reg     <= last_next;
                suppress_reg <= suppress_next;
                paused_reg   <= paused_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (step_en)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_data  = mid_reg;

    a_paused_tracks_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        paused_reg == (state_reg == dipf_pkg::ST_SLEEP))
        else $error("paused flag out of step with sleep state");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("display state not one-hot");

    a_touch_zero_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (in_item_reg.action == dipf_pkg::ACT_ACTIVITY
                     || in_item_reg.action == dipf_pkg::ACT_WAKE))
        |=> (mid_reg.elapsed_ms == '0 && last_reg == $past(in_item_reg.now_ms)))
        else $error("activity did not restart the inactivity time");

    a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg |-> mid_reg.brightness <= dipf_pkg::BRIGHT_MAX)
        else $error("brightness above full scale");

endmodule

FILE: hdl/dipf_sec.sv
// ----------------------------------------------------------------------------
// dipf_sec
// Milliseconds-to-seconds conversion and result register.
// ----------------------------------------------------------------------------
module dipf_sec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mid_valid,
    output logic                mid_ready,
    input  dipf_pkg::mid_t      mid_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dipf_pkg::out_item_t out_data
);

    logic                           out_valid_reg;
    dipf_pkg::out_item_t            out_reg;
    dipf_pkg::out_item_t            out_next;
    logic [dipf_pkg::PROD_W-1:0]    prod;

    assign mid_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        prod = {{dipf_pkg::RECIP_W{1'b0}}, mid_data.elapsed_ms}
             * {{dipf_pkg::MS_W{1'b0}}, dipf_pkg::SEC_RECIP};
        out_next.power_state      = mid_data.power_state;
        out_next.brightness       = mid_data.brightness;
        out_next.brightness_write = mid_data.brightness_write;
        out_next.render_paused    = mid_data.render_paused;
        out_next.touch_suppressed = mid_data.touch_suppressed;
        out_next.inactive_seconds =
            prod[dipf_pkg::SEC_SHIFT +: dipf_pkg::SEC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_ready && mid_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_write_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.brightness_write |-> out_reg.brightness == '0)
        else $error("brightness level without a write");

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.inactive_seconds <= 23'd4294967)
        else $error("inactive seconds out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result changed while stalled");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for display_inactivity_power_fsm_unit. A queue-fed driver
// and a monitor run as clocked processes. Each accepted input transaction goes
// through a behavioral copy of the dim/sleep state machine. The copy keeps its
// own timers, flags and register settings, and every result is compared
// against the oldest queued prediction. Stimulus is a directed walk through
// the timer thresholds, then random phases under changing register settings
// and idle patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MS_PER_S     = 1000;
    localparam int          RAND_PHASES  = 12;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          DRAIN_CYCLES = 8;

    localparam logic [dipf_pkg::CFG_IDX_W-1:0] REG_SPARE =
        dipf_pkg::REG_SLEEP_BRIGHT + 3'd1;
    localparam logic [2:0] ACT_NONE = dipf_pkg::ACT_UNSUP + 3'd1;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [dipf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dipf_pkg::TMO_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    dipf_pkg::in_item_t             in_data;
    logic                           out_valid;
    logic                           out_ready;
    dipf_pkg::out_item_t            out_data;

    display_inactivity_power_fsm_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dipf_pkg::in_item_t  pending_in[$];
    dipf_pkg::out_item_t expected_out[$];
    int                  mismatch_count = 0;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    // display state tracked alongside the block
    logic [1:0]                 disp_mode;
    logic [dipf_pkg::MS_W-1:0]  last_act_ms;
    logic                       touch_hold;
    logic                       paused;
    logic [dipf_pkg::TMO_W-1:0] dim_tmo_s;
    logic [dipf_pkg::TMO_W-1:0] sleep_tmo_s;
    logic [dipf_pkg::PCT_W-1:0] act_pct;
    logic [dipf_pkg::PCT_W-1:0] dim_pct;
    logic [dipf_pkg::PCT_W-1:0] sleep_pct;

    // stimulus timeline
    logic [dipf_pkg::MS_W-1:0]  gen_now;
    logic [dipf_pkg::MS_W-1:0]  gen_last;

    function automatic logic [dipf_pkg::PCT_W-1:0] cap_pct(logic [dipf_pkg::PCT_W-1:0] p);
        return (p > dipf_pkg::BRIGHT_MAX) ? dipf_pkg::BRIGHT_MAX : p;
    endfunction

    function automatic logic [dipf_pkg::MS_W-1:0] idle_ms(logic [dipf_pkg::MS_W-1:0] now);
        return (now >= last_act_ms) ? now - last_act_ms : '0;
    endfunction

    function automatic dipf_pkg::out_item_t advance_display(dipf_pkg::in_item_t t);
        dipf_pkg::out_item_t       r;
        logic [dipf_pkg::MS_W-1:0] gap;
        logic [dipf_pkg::MS_W-1:0] dim_ms;
        logic [dipf_pkg::MS_W-1:0] sleep_lim_ms;
        logic                      to_sleep;
        r            = '0;
        to_sleep     = 1'b0;
        gap          = idle_ms(t.now_ms);
        dim_ms       = dipf_pkg::MS_W'(dim_tmo_s) * MS_PER_S;
        sleep_lim_ms = dipf_pkg::MS_W'(sleep_tmo_s) * MS_PER_S;
        case (t.action)
            dipf_pkg::ACT_EVAL:
            begin
                if ((disp_mode == dipf_pkg::PS_ACTIVE || disp_mode == dipf_pkg::PS_DIMMED)
                    && gap >= sleep_lim_ms)
                    to_sleep = 1'b1;
                else if (disp_mode == dipf_pkg::PS_ACTIVE && gap >= dim_ms)
                begin
                    disp_mode          = dipf_pkg::PS_DIMMED;
                    r.brightness       = cap_pct(dim_pct);
                    r.brightness_write = 1'b1;
                end
            end
            dipf_pkg::ACT_ACTIVITY, dipf_pkg::ACT_WAKE:
            begin
                if (t.action == dipf_pkg::ACT_WAKE || disp_mode != dipf_pkg::PS_ACTIVE)
                begin
                    if (disp_mode != dipf_pkg::PS_ACTIVE)
                        touch_hold = 1'b1;
                    disp_mode          = dipf_pkg::PS_ACTIVE;
                    paused             = 1'b0;
                    r.brightness       = act_pct;
                    r.brightness_write = 1'b1;
                end
                last_act_ms = t.now_ms;
            end
            dipf_pkg::ACT_SLEEP:
                to_sleep = 1'b1;
            dipf_pkg::ACT_UNSUP:
                touch_hold = 1'b0;
            default:
                ;
        endcase
        if (to_sleep)
        begin
            disp_mode          = dipf_pkg::PS_SLEEP;
            paused             = 1'b1;
            r.brightness       = cap_pct(sleep_pct);
            r.brightness_write = 1'b1;
        end
        r.power_state      = disp_mode;
        r.render_paused    = paused;
        r.touch_suppressed = touch_hold;
        r.inactive_seconds = dipf_pkg::SEC_W'(idle_ms(t.now_ms) / MS_PER_S);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_out.push_back(advance_display(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_in.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_in.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        dipf_pkg::out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_out.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result expected none actual %p", $time, out_data);
                end
                else
                begin
                    want = expected_out.pop_front();
                    check_field("power_state", want.power_state, out_data.power_state);
                    check_field("brightness", want.brightness, out_data.brightness);
                    check_field("brightness_write", want.brightness_write,
                                out_data.brightness_write);
                    check_field("render_paused", want.render_paused, out_data.render_paused);
                    check_field("touch_suppressed", want.touch_suppressed,
                                out_data.touch_suppressed);
                    check_field("inactive_seconds", want.inactive_seconds,
                                out_data.inactive_seconds);
                end
            end
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic add_item(logic [2:0] action, logic [dipf_pkg::MS_W-1:0] now);
        dipf_pkg::in_item_t t;
        t.action = action;
        t.now_ms = now;
        pending_in.push_back(t);
        gen_now = now;
        if (action == dipf_pkg::ACT_ACTIVITY || action == dipf_pkg::ACT_WAKE)
            gen_last = now;
    endtask

    task automatic queue_random_items(int count);
        logic [2:0]                action;
        logic [dipf_pkg::MS_W-1:0] now;
        logic [dipf_pkg::MS_W-1:0] dim_ms;
        logic [dipf_pkg::MS_W-1:0] sleep_lim_ms;
        int                        pick;
        int                        off;
        dim_ms       = dipf_pkg::MS_W'(dim_tmo_s) * MS_PER_S;
        sleep_lim_ms = dipf_pkg::MS_W'(sleep_tmo_s) * MS_PER_S;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99, 0);
            off  = int'($urandom_range(2, 0)) - 1;
            if (pick < 30)
                now = gen_now + $urandom_range(3000, 0);
            else if (pick < 45)
                now = gen_last + dim_ms + dipf_pkg::MS_W'(off);
            else if (pick < 60)
                now = gen_last + sleep_lim_ms + dipf_pkg::MS_W'(off);
            else if (pick < 70)
                now = gen_last + $urandom_range(sleep_lim_ms + 5000, 0);
            else if (pick < 78)
                now = gen_last - $urandom_range(5000, 1);
            else
                now = $urandom;
            pick = $urandom_range(99, 0);
            if (pick < 45)
                action = dipf_pkg::ACT_EVAL;
            else if (pick < 63)
                action = dipf_pkg::ACT_ACTIVITY;
            else if (pick < 73)
                action = dipf_pkg::ACT_WAKE;
            else if (pick < 80)
                action = dipf_pkg::ACT_SLEEP;
            else if (pick < 90)
                action = dipf_pkg::ACT_UNSUP;
            else
                action = ACT_NONE + 3'($urandom_range(2, 0));
            add_item(action, now);
        end
    endtask

    task automatic write_reg(logic [dipf_pkg::CFG_IDX_W-1:0] idx,
                             logic [dipf_pkg::TMO_W-1:0] val);
        logic [dipf_pkg::PCT_W-1:0] pct;
        pct = val[dipf_pkg::PCT_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            dipf_pkg::REG_DIM_TMO:      dim_tmo_s   = val;
            dipf_pkg::REG_SLEEP_TMO:    sleep_tmo_s = val;
            dipf_pkg::REG_ACT_BRIGHT:   act_pct     =
                (pct > dipf_pkg::BRIGHT_MAX) ? dipf_pkg::BRIGHT_MAX :
                (pct < dipf_pkg::BRIGHT_MIN) ? dipf_pkg::BRIGHT_MIN : pct;
            dipf_pkg::REG_DIM_BRIGHT:   dim_pct     = pct;
            dipf_pkg::REG_SLEEP_BRIGHT: sleep_pct   = pct;
            default:                    ;
        endcase
    endtask

    task automatic load_settings(logic [dipf_pkg::TMO_W-1:0] dim_s,
                                 logic [dipf_pkg::TMO_W-1:0] sleep_s,
                                 logic [dipf_pkg::TMO_W-1:0] act_b,
                                 logic [dipf_pkg::TMO_W-1:0] dim_b,
                                 logic [dipf_pkg::TMO_W-1:0] sleep_b);
        write_reg(dipf_pkg::REG_DIM_TMO, dim_s);
        write_reg(dipf_pkg::REG_SLEEP_TMO, sleep_s);
        write_reg(dipf_pkg::REG_ACT_BRIGHT, act_b);
        write_reg(dipf_pkg::REG_DIM_BRIGHT, dim_b);
        write_reg(dipf_pkg::REG_SLEEP_BRIGHT, sleep_b);
        write_reg(REG_SPARE + 3'($urandom_range(2, 0)), dipf_pkg::TMO_W'($urandom));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        while (pending_in.size() != 0 || in_valid || expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        send_idle_pct = 37;
        recv_idle_pct = 68;
        disp_mode   = dipf_pkg::PS_ACTIVE;
        last_act_ms = '0;
        touch_hold  = 1'b0;
        paused      = 1'b0;
        dim_tmo_s   = dipf_pkg::TMO_W'(60);
        sleep_tmo_s = dipf_pkg::TMO_W'(120);
        act_pct     = dipf_pkg::BRIGHT_MAX;
        dim_pct     = dipf_pkg::PCT_W'(20);
        sleep_pct   = '0;
        gen_now     = '0;
        gen_last    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        add_item(dipf_pkg::ACT_EVAL, 32'd0);
        add_item(dipf_pkg::ACT_EVAL, 32'd59999);
        add_item(dipf_pkg::ACT_EVAL, 32'd60000);
        add_item(dipf_pkg::ACT_EVAL, 32'd119999);
        add_item(dipf_pkg::ACT_EVAL, 32'd120000);
        add_item(dipf_pkg::ACT_EVAL, 32'd200000);
        add_item(dipf_pkg::ACT_ACTIVITY, 32'd200500);
        add_item(dipf_pkg::ACT_UNSUP, 32'd200600);
        add_item(dipf_pkg::ACT_ACTIVITY, 32'd210000);
        add_item(dipf_pkg::ACT_EVAL, 32'd100);
        add_item(dipf_pkg::ACT_WAKE, 32'd220000);
        add_item(dipf_pkg::ACT_SLEEP, 32'd230000);
        add_item(dipf_pkg::ACT_EVAL, 32'd400000);
        add_item(dipf_pkg::ACT_WAKE, 32'hFFFF_FFFF);
        add_item(ACT_NONE, 32'd0);
        add_item(ACT_NONE + 3'd1, 32'hFFFF_FFFF);
        add_item(ACT_NONE + 3'd2, 32'h5555_AAAA);
        add_item(dipf_pkg::ACT_EVAL, 32'hFFFF_FFFF);
        add_item(dipf_pkg::ACT_UNSUP, 32'd0);
        add_item(dipf_pkg::ACT_ACTIVITY, 32'd0);
        add_item(dipf_pkg::ACT_EVAL, 32'hFFFF_FFFF);
        add_item(dipf_pkg::ACT_SLEEP, 32'hAAAA_5555);
        add_item(dipf_pkg::ACT_ACTIVITY, 32'h8000_0000);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       load_settings(17'd10, 17'd11, 17'd10, 17'd0, 17'd0);
                1:       load_settings(17'd86400, 17'd86400, 17'd100, 17'd100, 17'd100);
                2:       load_settings(17'd0, 17'd0, 17'd0, 17'd127, 17'd101);
                3:       load_settings(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FF80, 17'h1FFFF);
                4:       load_settings(17'd20, 17'd10, 17'd55, 17'd30, 17'd5);
                5, 6:    load_settings(dipf_pkg::TMO_W'($urandom), dipf_pkg::TMO_W'($urandom),
                                       dipf_pkg::TMO_W'($urandom), dipf_pkg::TMO_W'($urandom),
                                       dipf_pkg::TMO_W'($urandom));
                default: load_settings(dipf_pkg::TMO_W'($urandom_range(40, 0)),
                                       dipf_pkg::TMO_W'($urandom_range(60, 0)),
                                       dipf_pkg::TMO_W'($urandom), dipf_pkg::TMO_W'($urandom),
                                       dipf_pkg::TMO_W'($urandom));
            endcase
            case (ph / 4)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            queue_random_items(PHASE_ITEMS);
            settle();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
